FILE: rtl/wps_pkg.sv
// shared types, constants and helpers of the path name sanitizer
`default_nettype none
package wps_pkg;

    localparam logic [7:0] ChSlash    = 8'h2F;
    localparam logic [7:0] ChDot      = 8'h2E;
    localparam logic [7:0] ChUnder    = 8'h5F;
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChDel      = 8'h7F;
    localparam logic [7:0] ChHigh     = 8'h80;
    localparam logic [7:0] EscLead    = 8'hEF;
    localparam logic [7:0] EscCont    = 8'h80;
    localparam logic [7:0] LowMask    = 8'h3F;
    localparam logic [7:0] CaseOffset = 8'h20;
    localparam logic [2:0] LenSat     = 3'd7;
    localparam logic [2:0] LenShort   = 3'd3;
    localparam logic [2:0] LenLong    = 3'd4;

    // reserved stems, upper case
    localparam logic [23:0] StemCon = {8'h43, 8'h4F, 8'h4E};
    localparam logic [23:0] StemPrn = {8'h50, 8'h52, 8'h4E};
    localparam logic [23:0] StemAux = {8'h41, 8'h55, 8'h58};
    localparam logic [23:0] StemNul = {8'h4E, 8'h55, 8'h4C};
    localparam logic [23:0] StemCom = {8'h43, 8'h4F, 8'h4D};
    localparam logic [23:0] StemLpt = {8'h4C, 8'h50, 8'h54};

    // component tracking state
    typedef struct packed {
        logic [2:0]      len;
        logic [2:0][7:0] head;
        logic            fourth_digit;
    } t_comp;

    // result bytes of one request, last_idx is the index of the final byte
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            path_end;
    } t_result;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            u = c - CaseOffset;
        end
        return u;
    endfunction

    function automatic logic [23:0] stem_of(input t_comp s);
        return {to_upper(s.head[0]), to_upper(s.head[1]), to_upper(s.head[2])};
    endfunction

    function automatic logic is_reserved(input t_comp s);
        logic [23:0] st;
        logic        r;
        st = stem_of(s);
        r  = 1'b0;
        if (s.len == LenShort) begin
            r = (st == StemCon) || (st == StemPrn) || (st == StemAux) || (st == StemNul);
        end else if (s.len == LenLong && s.fourth_digit) begin
            r = (st == StemCom) || (st == StemLpt);
        end
        return r;
    endfunction

    function automatic logic is_unsafe(input logic [7:0] b, input logic esc_high);
        logic u;
        if (b < ChSpace || b == ChDel) begin
            u = 1'b1;
        end else if (b >= ChHigh) begin
            u = esc_high;
        end else begin
            u = (b == 8'h3C) || (b == 8'h3E) || (b == 8'h3A) || (b == 8'h7C) ||
                (b == 8'h3F) || (b == 8'h2A) || (b == 8'h5C) || (b == 8'h22);
        end
        return u;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/wps_comp_track.sv
// component state registers and per-byte result building
`default_nettype none
module wps_comp_track (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire logic             i_esc_high,
    output wps_pkg::t_result      o_res
);

    wps_pkg::t_comp r_comp;
    wps_pkg::t_comp n_comp;
    wps_pkg::t_comp upd;
    logic           sep;

    // component state after this byte, before the end-of-path clear
    always_comb begin
        sep = (i_byte == wps_pkg::ChSlash) || (i_byte == wps_pkg::ChDot);
        upd = r_comp;
        if (sep) begin
            upd = '0;
        end else begin
            if (r_comp.len < wps_pkg::LenShort) begin
                upd.head[r_comp.len[1:0]] = i_byte;
            end
            if (r_comp.len == wps_pkg::LenShort) begin
                upd.fourth_digit = (i_byte >= 8'h31) && (i_byte <= 8'h39);
            end
            if (r_comp.len < wps_pkg::LenSat) begin
                upd.len = r_comp.len + 3'd1;
            end
        end
        n_comp = i_last ? '0 : upd;
    end

    // result bytes for this request
    always_comb begin
        o_res          = '0;
        o_res.path_end = i_last;
        if (sep) begin
            if (wps_pkg::is_reserved(r_comp)) begin
                o_res.bytes[0] = wps_pkg::ChUnder;
                o_res.bytes[1] = i_byte;
                o_res.last_idx = 2'd1;
            end else begin
                o_res.bytes[0] = i_byte;
                o_res.last_idx = 2'd0;
            end
        end else if (wps_pkg::is_unsafe(i_byte, i_esc_high)) begin
            o_res.bytes[0] = wps_pkg::EscLead;
            o_res.bytes[1] = wps_pkg::EscCont | {2'b00, i_byte[7:6]};
            o_res.bytes[2] = wps_pkg::EscCont | (i_byte & wps_pkg::LowMask);
            o_res.last_idx = 2'd2;
        end else begin
            o_res.bytes[0] = i_byte;
            o_res.last_idx = 2'd0;
        end
        // suffix at end of path for a reserved final component
        if (i_last && o_res.last_idx != 2'd2 && wps_pkg::is_reserved(upd)) begin
            case (o_res.last_idx)
                2'd0: begin
                    o_res.bytes[1] = wps_pkg::ChUnder;
                    o_res.last_idx = 2'd1;
                end
                2'd1: begin
                    o_res.bytes[2] = wps_pkg::ChUnder;
                    o_res.last_idx = 2'd2;
                end
                default: begin
                    o_res.last_idx = o_res.last_idx;
                end
            endcase
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp <= '0;
        end else if (i_fire) begin
            r_comp <= n_comp;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wps_out_buf.sv
// result register that hands out one byte per cycle while i_ready is high
`default_nettype none
module wps_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire wps_pkg::t_result i_res,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_run_end,
    output logic                  o_path_end
);

    logic            r_valid;
    logic [1:0]      r_idx;
    logic [1:0]      r_last_idx;
    logic [2:0][7:0] r_bytes;
    logic            r_path_end;
    logic            take;

    // current byte and its end flags
    always_comb begin
        case (r_idx)
            2'd0:    o_byte = r_bytes[0];
            2'd1:    o_byte = r_bytes[1];
            2'd2:    o_byte = r_bytes[2];
            default: o_byte = r_bytes[0];
        endcase
        o_valid    = r_valid;
        o_run_end  = (r_idx == r_last_idx);
        o_path_end = o_run_end & r_path_end;
        take       = r_valid & i_ready;
        o_can_load = !r_valid || (take && o_run_end);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take && o_run_end) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes    <= i_res.bytes;
            r_last_idx <= i_res.last_idx;
            r_path_end <= i_res.path_end;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/win_path_name_sanitizer_unit.sv
// top level of the windows path name sanitizer
// One path byte enters per request and yields one to three output bytes: the byte itself,
// a three-byte escape EF,80|(b>>6),80|(b&3F) for unsafe bytes, and a '_' ahead of a
// separator or after the final byte when a component is a reserved device name. A byte
// that yields one output byte frees the input as it is taken, so plain text streams at one
// byte per cycle while m_axis_tready is high; each extra output byte holds the input back
// while the result register drains one byte per cycle unless stalled. The user must write
// escape_high_bytes via the cfg channel only while idle; the block does not enforce this.
`default_nettype none
module win_path_name_sanitizer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_data,     // escape_high_bytes
    // input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // last
    // output stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] run_end
    output logic            m_axis_tlast    // path_end
);

    logic             r_esc_high;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             can_load;
    logic             load;
    wps_pkg::t_result res;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_high <= 1'b0;
        end else if (i_cfg_valid) begin
            r_esc_high <= i_cfg_data;
        end
    end

    // input register
    assign load          = r_in_valid & can_load;
    assign s_axis_tready = !r_in_valid || can_load;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // component tracking and result building
    wps_comp_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (load),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_esc_high (r_esc_high),
        .o_res      (res)
    );

    // result register
    wps_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_run_end  (m_axis_tuser),
        .o_path_end (m_axis_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/wps_checker.sv
// port-level checks of the sanitizer and their binding
`default_nettype none
module wps_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // path end only on the final byte of a request
    a_path_end_on_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("path end without run end");

    // a multi-byte result drains without gaps
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser) |=> m_axis_tvalid)
        else $error("output gap inside a run");

    // stalled output holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled output changed");

endmodule

bind win_path_name_sanitizer_unit wps_checker u_wps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

FILE: dv/tb_top.sv
// testbench of the path name sanitizer: streamed paths, escape register, scoreboard check
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // ascii codes the predictor and the path generator work with
    localparam logic [7:0] ByteSlash = 8'h2F;
    localparam logic [7:0] ByteDot   = 8'h2E;
    localparam logic [7:0] ByteUnder = 8'h5F;
    localparam logic [7:0] ByteDel   = 8'h7F;
    localparam logic [7:0] EscFirst  = 8'hEF;
    localparam logic [7:0] EscMark   = 8'h80;
    localparam logic [23:0] DevCon = "CON";
    localparam logic [23:0] DevPrn = "PRN";
    localparam logic [23:0] DevAux = "AUX";
    localparam logic [23:0] DevNul = "NUL";
    localparam logic [23:0] DevCom = "COM";
    localparam logic [23:0] DevLpt = "LPT";
    localparam int HoldCycles = 60;
    localparam int PhaseRequests = 110;

    // kinds of path component the random part builds
    typedef enum int {
        CompDevice,
        CompNearDevice,
        CompRandom,
        CompEmpty
    } t_comp_kind;

    // one output byte as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       path_end;
    } t_path_beat;

    // tracks the component state and holds the output bytes still to come
    class t_path_scoreboard;
        bit         esc_high;
        logic [2:0] comp_len;
        logic [7:0] head [3];
        bit         fourth_digit;
        t_path_beat expected[$];
        int         errors;

        function void clear_comp();
            comp_len     = 3'd0;
            head[0]      = 8'h00;
            head[1]      = 8'h00;
            head[2]      = 8'h00;
            fourth_digit = 1'b0;
        endfunction

        function void set_escape(bit v);
            esc_high = v;
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            if (c >= "a" && c <= "z") begin
                return c - 8'd32;
            end
            return c;
        endfunction

        // exact device name match on the current component
        function bit is_device();
            logic [23:0] s;
            s = {fold(head[0]), fold(head[1]), fold(head[2])};
            if (comp_len == 3'd3) begin
                return s == DevCon || s == DevPrn || s == DevAux || s == DevNul;
            end
            if (comp_len == 3'd4 && fourth_digit) begin
                return s == DevCom || s == DevLpt;
            end
            return 1'b0;
        endfunction

        function bit needs_escape(logic [7:0] b);
            if (b < 8'h20 || b == ByteDel) begin
                return 1'b1;
            end
            if (b[7]) begin
                return esc_high;
            end
            case (b)
                "<", ">", ":", "|", "?", "*", "\\", "\"": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // predict the output bytes of one accepted request
        function void note_input(logic [7:0] b, logic is_last);
            logic [7:0] outs[$];
            t_path_beat beat;
            if (b == ByteSlash || b == ByteDot) begin
                if (is_device()) begin
                    outs.push_back(ByteUnder);
                end
                outs.push_back(b);
                clear_comp();
            end else begin
                if (needs_escape(b)) begin
                    outs.push_back(EscFirst);
                    outs.push_back(EscMark | {2'b00, b[7:6]});
                    outs.push_back(EscMark | {2'b00, b[5:0]});
                end else begin
                    outs.push_back(b);
                end
                if (comp_len < 3'd3) begin
                    head[comp_len] = b;
                end
                if (comp_len == 3'd3) begin
                    fourth_digit = (b >= "1" && b <= "9");
                end
                if (comp_len != 3'd7) begin
                    comp_len = comp_len + 3'd1;
                end
            end
            if (is_last) begin
                if (outs.size() < 3 && is_device()) begin
                    outs.push_back(ByteUnder);
                end
                clear_comp();
            end
            foreach (outs[i]) begin
                beat.data     = outs[i];
                beat.run_end  = (i == outs.size() - 1);
                beat.path_end = is_last && (i == outs.size() - 1);
                expected.push_back(beat);
            end
        endfunction

        function void check_result(logic [7:0] d, logic re, logic pe);
            t_path_beat want;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %h run_end %b path_end %b",
                         $time, d, re, pe);
                return;
            end
            want = expected.pop_front();
            if (want.data !== d || want.run_end !== re || want.path_end !== pe) begin
                errors++;
                $display({"%0t: expected byte %h run_end %b path_end %b, ",
                          "actual byte %h run_end %b path_end %b"},
                         $time, want.data, want.run_end, want.path_end, d, re, pe);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    t_path_scoreboard sb;
    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_ask;
    int hold_seen;
    int hold_left;
    int requests_sent;
    logic [7:0] path_bytes[$];

    win_path_name_sanitizer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // output side: check accepted bytes, random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        if (hold_ask != hold_seen) begin
            hold_seen     <= hold_ask;
            hold_left     <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // run limit
    initial begin
        #4ms;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_input(b, is_last);
        requests_sent++;
    endtask

    task automatic send_text(input string s, input bit ends_path);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], ends_path && i == s.len() - 1);
        end
    endtask

    task automatic wait_drained();
        while (sb.expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only with the block drained
    task automatic write_escape(input bit v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        sb.set_escape(v);
    endtask

    function automatic logic [23:0] device_stem(input int k);
        case (k)
            0: return DevCon;
            1: return DevPrn;
            2: return DevAux;
            3: return DevNul;
            4: return DevCom;
            default: return DevLpt;
        endcase
    endfunction

    // a path of one to four components, mostly device names and near misses
    task automatic build_path();
        int          ncomp;
        int          pick;
        int          k;
        t_comp_kind  kind;
        logic [23:0] stem;
        logic [7:0]  c;
        path_bytes.delete();
        ncomp = $urandom_range(4, 1);
        for (int i = 0; i < ncomp; i++) begin
            pick = $urandom_range(99);
            kind = pick < 40 ? CompDevice : pick < 65 ? CompNearDevice :
                   pick < 90 ? CompRandom : CompEmpty;
            if (kind == CompDevice || kind == CompNearDevice) begin
                k = $urandom_range(5);
                stem = device_stem(k);
                for (int j = 2; j >= 0; j--) begin
                    c = stem[j*8 +: 8];
                    if ($urandom_range(1)) begin
                        c = c | 8'h20;
                    end
                    path_bytes.push_back(c);
                end
                if (kind == CompDevice) begin
                    if (k >= 4) begin
                        path_bytes.push_back(8'($urandom_range("9", "1")));
                    end
                end else begin
                    case ($urandom_range(3))
                        0: void'(path_bytes.pop_back());
                        1: path_bytes.push_back(8'($urandom_range(8'h7E, 8'h21)));
                        2: path_bytes.push_back(k >= 4 ? "0" : "5");
                        default: begin
                            path_bytes.push_back(8'($urandom_range("9", "1")));
                            path_bytes.push_back("x");
                        end
                    endcase
                end
            end else if (kind == CompRandom) begin
                repeat ($urandom_range(8, 1)) begin
                    path_bytes.push_back(8'($urandom_range(255, 1)));
                end
            end
            if (i < ncomp - 1 || $urandom_range(9) == 0) begin
                path_bytes.push_back($urandom_range(1) ? ByteSlash : ByteDot);
            end
        end
        if (path_bytes.size() == 0) begin
            path_bytes.push_back(ByteSlash);
        end
    endtask

    // one random phase: idling mix, register value, optional long output hold-off
    task automatic run_phase(input int snd_pct, input int rcv_pct, input bit esc,
                             input bit hold);
        int start_count;
        write_escape(esc);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        if (hold) begin
            hold_ask <= hold_ask + 1;
        end
        start_count = requests_sent;
        while (requests_sent - start_count < PhaseRequests) begin
            if ($urandom_range(99) < 15) begin
                send_byte(8'($urandom_range(255, 1)), $urandom_range(19) == 0);
            end else begin
                build_path();
                foreach (path_bytes[i]) begin
                    send_byte(path_bytes[i], i == path_bytes.size() - 1);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // main sequence
    initial begin
        sb = new();
        sb.clear_comp();
        sb.set_escape(1'b0);
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        hold_ask      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        requests_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: device names at separator and at path end, escapes, extremes
        write_escape(1'b0);
        send_text("nUl.", 1'b0);
        send_text("Com7", 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(ByteDel, 1'b0);
        send_byte("<", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("\"", 1'b1);
        send_text("/", 1'b1);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b1);
        s_axis_tvalid <= 1'b0;
        write_escape(1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(ByteSlash, 1'b0);
        send_text("prn", 1'b1);
        send_byte(8'hFF, 1'b1);
        s_axis_tvalid <= 1'b0;

        // random phases
        run_phase(14, 58, 1'b1, 1'b0);
        run_phase(58, 14, 1'b0, 1'b0);
        run_phase(0, 0, 1'b1, 1'b1);

        wait_drained();
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
